// ===== hdl/mbd_pkg.sv =====
package mbd_pkg;

  // Pixel and sum widths
  localparam int PIX_W    = 8;
  localparam int NUM_CHAN = 4;
  localparam int SUM_W    = PIX_W + 1;
  localparam int LINE_W   = NUM_CHAN * SUM_W;

  // Counter and register widths
  localparam int CNT_W      = 12;
  localparam int DIM_W      = 13;
  localparam int CHAN_CNT_W = 3;

  // Limits and defaults
  localparam int DEF_MAX_WIDTH = 4096;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int DIM_MAX       = (1 << DIM_W) - 1;

  // Configuration port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } cfg_reg_t;

endpackage

// ===== hdl/mbd_pix_if.sv =====
interface mbd_pix_if;
  logic                     valid;
  logic                     ready;
  logic [mbd_pkg::PIX_W-1:0] chan0;
  logic [mbd_pkg::PIX_W-1:0] chan1;
  logic [mbd_pkg::PIX_W-1:0] chan2;
  logic [mbd_pkg::PIX_W-1:0] chan3;

  modport source (output valid, chan0, chan1, chan2, chan3, input ready);
  modport sink   (input valid, chan0, chan1, chan2, chan3, output ready);
endinterface

// ===== hdl/mbd_avg_if.sv =====
interface mbd_avg_if;
  logic                     valid;
  logic                     ready;
  logic [mbd_pkg::PIX_W-1:0] avg0;
  logic [mbd_pkg::PIX_W-1:0] avg1;
  logic [mbd_pkg::PIX_W-1:0] avg2;
  logic [mbd_pkg::PIX_W-1:0] avg3;
  logic                     frame_end;

  modport source (output valid, avg0, avg1, avg2, avg3, frame_end, input ready);
  modport sink   (input valid, avg0, avg1, avg2, avg3, frame_end, output ready);
endinterface

// ===== hdl/mbd_line_ram.sv =====
// Line store of horizontal pair sums: one write port, one registered read port
module mbd_line_ram #(
  parameter int DEPTH = mbd_pkg::DEF_MAX_WIDTH / 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [mbd_pkg::LINE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [mbd_pkg::LINE_W-1:0] rd_data
);

  logic [mbd_pkg::LINE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/mip_box_downsample.sv =====
// 2x2 box-filter mip level generator, raster-order pixel stream in and out.
// Each output pixel passes stage 1 and the output register after the input
// pixel that completes its block is taken. One input pixel per clock unless
// the output stalls, bounded by the line store's one read and one write port.
// Reset clears counters, pipeline valids and the registers (width 1, height 1,
// 4 channels); the line store is not cleared and needs no clearing pass.
module mip_box_downsample #(
  parameter int MAX_WIDTH = mbd_pkg::DEF_MAX_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mbd_pkg::APB_AW-1:0] paddr,
  input  logic [mbd_pkg::APB_DW-1:0] pwdata,
  output logic [mbd_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  // pixel streams
  mbd_pix_if.sink                    pix_in,
  mbd_avg_if.source                  avg_out
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int WCAP       = (MAX_WIDTH > mbd_pkg::DIM_MAX) ? mbd_pkg::DIM_MAX : MAX_WIDTH;
  localparam int CW         = mbd_pkg::CNT_W;
  localparam int DW         = mbd_pkg::DIM_W;
  localparam int SW         = mbd_pkg::SUM_W;
  localparam int PW         = mbd_pkg::PIX_W;
  localparam int NC         = mbd_pkg::NUM_CHAN;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [DW-1:0]                   image_width;
  logic [DW-1:0]                   image_height;
  logic [mbd_pkg::CHAN_CNT_W-1:0]  channel_count;
  logic                            cfg_wr;
  logic                            cfg_hit;
  mbd_pkg::cfg_reg_t               cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = mbd_pkg::cfg_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_sel)
      mbd_pkg::REG_IMAGE_WIDTH,
      mbd_pkg::REG_IMAGE_HEIGHT,
      mbd_pkg::REG_CHANNEL_COUNT: cfg_hit = 1'b1;
      default:                    cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= DW'(1);
      image_height  <= DW'(1);
      channel_count <= mbd_pkg::CHAN_CNT_W'(4);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        mbd_pkg::REG_IMAGE_WIDTH:   image_width   <= pwdata[DW-1:0];
        mbd_pkg::REG_IMAGE_HEIGHT:  image_height  <= pwdata[DW-1:0];
        mbd_pkg::REG_CHANNEL_COUNT: channel_count <= pwdata[mbd_pkg::CHAN_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      mbd_pkg::REG_IMAGE_WIDTH:   prdata = 32'(image_width);
      mbd_pkg::REG_IMAGE_HEIGHT:  prdata = 32'(image_height);
      mbd_pkg::REG_CHANNEL_COUNT: prdata = 32'(channel_count);
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Effective geometry
  // ---------------------------------------------------------------
  logic [DW-1:0]                  eff_w;
  logic [DW-1:0]                  eff_h;
  logic [CW-1:0]                  out_w;
  logic [CW-1:0]                  out_h;
  logic [mbd_pkg::CHAN_CNT_W-1:0] eff_nc;
  logic                           w_is1;
  logic                           h_is1;

  always_comb begin
    eff_w = image_width;
    if (image_width == '0) eff_w = DW'(1);
    if (32'(image_width) > WCAP) eff_w = DW'(WCAP);
    eff_h = image_height;
    if (image_height == '0) eff_h = DW'(1);
    if (32'(image_height) > mbd_pkg::HEIGHT_LIMIT) eff_h = DW'(mbd_pkg::HEIGHT_LIMIT);
    eff_nc = channel_count;
    if (channel_count == '0) eff_nc = mbd_pkg::CHAN_CNT_W'(1);
    if (channel_count > mbd_pkg::CHAN_CNT_W'(NC)) eff_nc = mbd_pkg::CHAN_CNT_W'(NC);
  end

  assign w_is1 = (eff_w == DW'(1));
  assign h_is1 = (eff_h == DW'(1));
  assign out_w = w_is1 ? CW'(1) : eff_w[DW-1:1];
  assign out_h = h_is1 ? CW'(1) : eff_h[DW-1:1];

  // ---------------------------------------------------------------
  // Stage 0: pair sums, line store write or read issue
  // ---------------------------------------------------------------
  logic [CW-1:0]           col;
  logic [CW-1:0]           row;
  logic [NC*PW-1:0]        held_left;
  logic [NC*PW-1:0]        px;
  logic [NC*PW-1:0]        left_px;
  logic [mbd_pkg::LINE_W-1:0] pair;
  logic [CW-2:0]           ox;
  logic [CW-2:0]           oy;
  logic [31:0]             ox_ext;
  logic                    have_pair;
  logic                    in_line;
  logic                    line_wr;
  logic                    emit;
  logic                    last_px;
  logic                    in_xfer;
  logic                    out_free;
  logic [DW-1:0]           col_inc;
  logic [DW-1:0]           row_inc;

  logic                    s1_valid;
  logic [mbd_pkg::LINE_W-1:0] s1_pair;
  logic                    s1_dbl;
  logic                    s1_last;
  logic [mbd_pkg::LINE_W-1:0] upper;

  assign px = {pix_in.chan3, pix_in.chan2, pix_in.chan1, pix_in.chan0};

  assign out_free     = !avg_out.valid || avg_out.ready;
  assign pix_in.ready = !s1_valid || out_free;
  assign in_xfer      = pix_in.valid && pix_in.ready;

  always_comb begin
    left_px   = w_is1 ? px : held_left;
    ox        = w_is1 ? '0 : col[CW-1:1];
    oy        = row[CW-1:1];
    have_pair = w_is1 ? (col == '0) : (col[0] && ({1'b0, col[CW-1:1]} < out_w));
    ox_ext    = 32'(ox);
    in_line   = ox_ext < LINE_DEPTH;
    line_wr   = have_pair && in_line && (h_is1 || !row[0]);
    emit      = have_pair && in_line && (h_is1 || (row[0] && ({1'b0, oy} < out_h)));
    last_px   = ({1'b0, ox} == out_w - CW'(1)) && ({1'b0, oy} == out_h - CW'(1));
    for (int c = 0; c < NC; c++) begin
      pair[c*SW +: SW] = {1'b0, left_px[c*PW +: PW]} + {1'b0, px[c*PW +: PW]};
    end
  end

  // hold the left pixel of each horizontal pair
  always_ff @(posedge clk) begin
    if (in_xfer && !w_is1 && !col[0]) begin
      held_left <= px;
    end
  end

  // raster position
  assign col_inc = {1'b0, col} + DW'(1);
  assign row_inc = {1'b0, row} + DW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_wr && cfg_hit) begin
      col <= '0;
      row <= '0;
    end else if (in_xfer) begin
      if (col_inc >= eff_w) begin
        col <= '0;
        row <= (row_inc >= eff_h) ? '0 : row_inc[CW-1:0];
      end else begin
        col <= col_inc[CW-1:0];
      end
    end
  end

  mbd_line_ram #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (in_xfer && line_wr),
    .wr_addr (ox_ext[AW-1:0]),
    .wr_data (pair),
    .rd_en   (in_xfer && emit && !h_is1),
    .rd_addr (ox_ext[AW-1:0]),
    .rd_data (upper)
  );

  // ---------------------------------------------------------------
  // Stage 1: add the upper pair sums from the line store
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= emit;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pair <= pair;
      s1_dbl  <= h_is1;
      s1_last <= last_px;
    end
  end

  logic [NC*PW-1:0] avg_next;

  always_comb begin
    logic [SW:0] sum4;
    for (int c = 0; c < NC; c++) begin
      sum4 = {1'b0, upper[c*SW +: SW]} + {1'b0, s1_pair[c*SW +: SW]};
      if (mbd_pkg::CHAN_CNT_W'(c) >= eff_nc) begin
        avg_next[c*PW +: PW] = '0;
      end else if (s1_dbl) begin
        // single row paired with itself
        avg_next[c*PW +: PW] = s1_pair[c*SW+1 +: PW];
      end else begin
        avg_next[c*PW +: PW] = sum4[SW:2];
      end
    end
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_out.valid <= 1'b0;
    end else if (out_free) begin
      avg_out.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      avg_out.avg0      <= avg_next[0*PW +: PW];
      avg_out.avg1      <= avg_next[1*PW +: PW];
      avg_out.avg2      <= avg_next[2*PW +: PW];
      avg_out.avg3      <= avg_next[3*PW +: PW];
      avg_out.frame_end <= s1_last;
    end
  end

endmodule
